[design/pcled_pkg.sv]
// Shared types and constants for the press-controlled LED chaser.
package pcled_pkg;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_LEFT  = 2'd1,
        MODE_RIGHT = 2'd2
    } mode_t;

    localparam int unsigned LED_COUNT   = 8;
    localparam int unsigned COUNT_WIDTH = 8;

    localparam logic [LED_COUNT-1:0]   LED_FIRST        = 8'h01;
    localparam logic [LED_COUNT-1:0]   LED_LAST         = 8'h80;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX        = 8'hFF;
    localparam logic [COUNT_WIDTH-1:0] LONG_PRESS_RESET = 8'd16;

    typedef struct packed {
        logic                   last_level;
        logic [COUNT_WIDTH-1:0] held_ticks;
        mode_t                  run_mode;
        logic [LED_COUNT-1:0]   lit_pattern;
    } pcled_state_t;

endpackage

[design/pcled_step.sv]
// Next-state logic for one button tick: press counter, mode change, LED rotation.
module pcled_step
    import pcled_pkg::*;
(
    input  pcled_state_t           cur_state,
    input  logic                   button_level,
    input  logic [COUNT_WIDTH-1:0] long_press_ticks,
    output pcled_state_t           next_state,
    output logic                   mode_changed
);

    logic                 released;
    logic                 long_press;
    mode_t                mode_next;
    logic [LED_COUNT-1:0] pattern_next;

    // press counter and release detect
    always_comb begin
        next_state            = cur_state;
        released              = 1'b0;
        next_state.last_level = button_level;
        if (button_level) begin
            released = !cur_state.last_level;
        end else if (cur_state.last_level) begin
            next_state.held_ticks = '0;
        end else if (cur_state.held_ticks != COUNT_MAX) begin
            next_state.held_ticks = cur_state.held_ticks + 1'b1;
        end
        next_state.run_mode    = mode_next;
        next_state.lit_pattern = pattern_next;
    end

    // counter is untouched on a release tick, so the held count is still current
    assign long_press = (cur_state.held_ticks >= long_press_ticks);

    always_comb begin
        mode_next = cur_state.run_mode;
        if (released) begin
            if (long_press) begin
                unique case (cur_state.run_mode)
                    MODE_OFF:   mode_next = MODE_LEFT;
                    MODE_LEFT:  mode_next = MODE_OFF;
                    MODE_RIGHT: mode_next = MODE_OFF;
                    default:    mode_next = cur_state.run_mode;
                endcase
            end else begin
                unique case (cur_state.run_mode)
                    MODE_LEFT:  mode_next = MODE_RIGHT;
                    MODE_RIGHT: mode_next = MODE_LEFT;
                    default:    mode_next = cur_state.run_mode;
                endcase
            end
        end
    end

    assign mode_changed = (mode_next != cur_state.run_mode);

    always_comb begin
        pattern_next = cur_state.lit_pattern;
        if (mode_changed) begin
            unique case (mode_next)
                MODE_OFF: pattern_next = '0;
                MODE_LEFT: begin
                    if (cur_state.lit_pattern == '0) pattern_next = LED_FIRST;
                end
                MODE_RIGHT: begin
                    if (cur_state.lit_pattern == '0) pattern_next = LED_LAST;
                end
                default: pattern_next = cur_state.lit_pattern;
            endcase
        end else begin
            unique case (cur_state.run_mode)
                MODE_LEFT: begin
                    // wrap the top LED around to LED 0
                    if (cur_state.lit_pattern[LED_COUNT-1]) pattern_next = LED_FIRST;
                    else pattern_next = {cur_state.lit_pattern[LED_COUNT-2:0], 1'b0};
                end
                MODE_RIGHT: begin
                    if (cur_state.lit_pattern[0]) pattern_next = LED_LAST;
                    else pattern_next = {1'b0, cur_state.lit_pattern[LED_COUNT-1:1]};
                end
                default: pattern_next = cur_state.lit_pattern;
            endcase
        end
    end

endmodule

[design/press_controlled_led_chaser_top.sv]
// Top level of the press-controlled LED chaser: state, threshold and result registers.
// Each accepted beat carries one sampled button level (0 = pressed) and yields exactly
// one result beat with the LED pattern, the mode and a mode-changed flag after that tick.
// The block takes one beat per cycle: the whole update is a single short combinational
// pass from the state registers into the result register, and the result register lets
// a new beat in whenever it is empty or being drained in the same cycle, so each result
// follows in the cycle after its beat, one beat per clock while m_ready stays high.
// long_press_ticks resets to 16 and is written through cfg_wr_en/cfg_wr_data.
module press_controlled_led_chaser_top
    import pcled_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [COUNT_WIDTH-1:0] cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_button_level,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [LED_COUNT-1:0]   m_led_pattern,
    output logic [1:0]             m_mode,
    output logic                   m_mode_changed
);

    pcled_state_t           state_reg;
    pcled_state_t           state_next;
    logic [COUNT_WIDTH-1:0] long_press_ticks_reg;
    logic                   m_valid_reg;
    logic                   mode_changed_next;
    logic                   mode_changed_reg;
    logic                   s_accept;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    pcled_step u_step (
        .cur_state        (state_reg),
        .button_level     (s_button_level),
        .long_press_ticks (long_press_ticks_reg),
        .next_state       (state_next),
        .mode_changed     (mode_changed_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_press_ticks_reg <= LONG_PRESS_RESET;
        end else if (cfg_wr_en) begin
            long_press_ticks_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.last_level  <= 1'b0;
            state_reg.held_ticks  <= '0;
            state_reg.run_mode    <= MODE_OFF;
            state_reg.lit_pattern <= '0;
            m_valid_reg           <= 1'b0;
            mode_changed_reg      <= 1'b0;
        end else begin
            if (s_accept) begin
                state_reg        <= state_next;
                mode_changed_reg <= mode_changed_next;
                m_valid_reg      <= 1'b1;
            end else if (m_ready) begin
                // drop the beat once taken
                m_valid_reg <= 1'b0;
            end
        end
    end

    // the result fields are the updated state itself
    assign m_valid        = m_valid_reg;
    assign m_led_pattern  = state_reg.lit_pattern;
    assign m_mode         = state_reg.run_mode;
    assign m_mode_changed = mode_changed_reg;

endmodule

[design/pcled_checker.sv]
// Port-level checker for the press-controlled LED chaser, bound to the top level.
module pcled_port_checker
    import pcled_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [LED_COUNT-1:0] m_led_pattern,
    input logic [1:0]           m_mode,
    input logic                 m_mode_changed
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_led_pattern) && $stable(m_mode)
            && $stable(m_mode_changed))
        else $error("stalled result beat changed or dropped");

    a_mode_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_mode == MODE_OFF || m_mode == MODE_LEFT || m_mode == MODE_RIGHT))
        else $error("mode code three on the result channel");

    a_off_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_mode == MODE_OFF |-> m_led_pattern == '0)
        else $error("LEDs lit while off");

    a_run_one_led: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_mode != MODE_OFF |-> $onehot(m_led_pattern))
        else $error("running mode without exactly one lit LED");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while the result register is full and stalled");

endmodule

bind press_controlled_led_chaser_top pcled_port_checker u_pcled_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_led_pattern  (m_led_pattern),
    .m_mode         (m_mode),
    .m_mode_changed (m_mode_changed)
);
